[sv/hce_pkg.sv]
// Shared types, constants and helpers of the chunked transfer encoder.
`timescale 1ns / 1ps
`default_nettype none
package hce_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int CHUNK_BITS = 16;
	localparam int LEN_FIELD_BITS = 24;
	localparam int CFG_BITS = 16;
	localparam int CMP_BITS = (LENGTH_BITS > CHUNK_BITS) ? LENGTH_BITS : CHUNK_BITS;
	localparam int NIB_MAX = (CHUNK_BITS + 3) / 4;
	localparam int HEX_BITS = NIB_MAX * 4;
	localparam int DIG_BITS = (NIB_MAX > 1) ? $clog2(NIB_MAX) : 1;
	localparam int QA = 2;
	localparam int QDEPTH = 1 << QA;

	localparam logic [CFG_BITS-1:0] MAX_CHUNK_RESET = 16'd4096;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A_OFS = 8'h57;
	localparam logic [3:0] HEX_MASK = 4'hf;

	typedef enum logic [1:0] {
		FUNC_BEGIN = 2'd0,
		FUNC_BYTE  = 2'd1,
		FUNC_FLUSH = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]                func;
		logic [7:0]                data;
		logic [LEN_FIELD_BITS-1:0] write_length;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [31:0] payload_total;
	} rsp_t;

	typedef struct packed {
		logic                  flush;
		logic                  header;
		logic                  trailer;
		logic [DIG_BITS-1:0]   top_dig;
		logic [CHUNK_BITS-1:0] chunk;
		logic [7:0]            data;
		logic [31:0]           cnt_pre;
		logic [31:0]           cnt_post;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [3:0] {
		ST_HEX,
		ST_HCR,
		ST_HLF,
		ST_DATA,
		ST_TCR,
		ST_TLF,
		ST_F0,
		ST_FCR1,
		ST_FLF1,
		ST_FCR2,
		ST_FLF2
	} step_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'h0, nib & HEX_MASK};
		if (nib > 4'd9) begin
			return ext + CH_A_OFS;
		end
		return ext + CH_ZERO;
	endfunction

endpackage
`default_nettype wire

[sv/hce_front.sv]
// Front end: accepts words, tracks write and chunk state, and queues emission jobs.
`timescale 1ns / 1ps
`default_nettype none
module hce_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire hce_pkg::req_t   req,
	input  wire logic            cfg_we,
	input  wire logic [hce_pkg::CFG_BITS-1:0] cfg_data,
	input  wire hce_pkg::q_stat_t stat,
	output logic                 push,
	output hce_pkg::job_t        job
);

	logic [hce_pkg::LENGTH_BITS-1:0] wr_q, wr_d;
	logic [hce_pkg::CHUNK_BITS-1:0]  cr_q, cr_d;
	logic [31:0]                     cnt_q, cnt_d;
	logic [hce_pkg::CFG_BITS-1:0]    maxc_cfg_q;

	logic                            accept;
	logic [hce_pkg::LENGTH_BITS-1:0] len;
	logic [hce_pkg::CHUNK_BITS-1:0]  maxc;
	logic [hce_pkg::CHUNK_BITS-1:0]  chunk;
	logic [hce_pkg::CHUNK_BITS-1:0]  cr_eff;
	logic [hce_pkg::HEX_BITS-1:0]    chunk_hex;
	logic [hce_pkg::DIG_BITS-1:0]    top_dig;
	logic [31:0]                     cnt_inc;

	assign req_stall = stat.full;
	assign accept = req_valid && !stat.full;
	assign len = hce_pkg::LENGTH_BITS'({8'd0, req.write_length});
	assign cnt_inc = cnt_q + 32'd1;

	always_comb begin
		maxc = maxc_cfg_q[hce_pkg::CHUNK_BITS-1:0];
		if (maxc == '0) begin
			maxc = hce_pkg::CHUNK_BITS'(1);
		end
		if (hce_pkg::CMP_BITS'(wr_q) < hce_pkg::CMP_BITS'(maxc)) begin
			chunk = hce_pkg::CHUNK_BITS'(hce_pkg::CMP_BITS'(wr_q));
		end else begin
			chunk = maxc;
		end
		cr_eff = (cr_q == '0) ? chunk : cr_q;
	end

	always_comb begin
		chunk_hex = hce_pkg::HEX_BITS'(chunk);
		top_dig = '0;
		for (int d = 0; d < hce_pkg::NIB_MAX; d++) begin
			if (chunk_hex[d*4 +: 4] != 4'h0) begin
				top_dig = hce_pkg::DIG_BITS'(d);
			end
		end
	end

	always_comb begin
		wr_d = wr_q;
		cr_d = cr_q;
		cnt_d = cnt_q;
		push = 1'b0;
		job.flush = 1'b0;
		job.header = (cr_q == '0);
		job.trailer = (cr_eff == hce_pkg::CHUNK_BITS'(1));
		job.top_dig = top_dig;
		job.chunk = chunk;
		job.data = req.data;
		job.cnt_pre = cnt_q;
		job.cnt_post = cnt_inc;
		case (req.func)
			hce_pkg::FUNC_BEGIN: begin
				wr_d = len;
				cr_d = '0;
			end
			hce_pkg::FUNC_BYTE: begin
				if (wr_q != '0) begin
					push = accept;
					wr_d = wr_q - hce_pkg::LENGTH_BITS'(1);
					cr_d = cr_eff - hce_pkg::CHUNK_BITS'(1);
					cnt_d = cnt_inc;
				end
			end
			hce_pkg::FUNC_FLUSH: begin
				push = accept;
				job.flush = 1'b1;
				job.cnt_post = cnt_q;
				wr_d = '0;
				cr_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			cr_q <= '0;
			cnt_q <= '0;
			maxc_cfg_q <= hce_pkg::MAX_CHUNK_RESET;
		end else begin
			if (accept) begin
				wr_q <= wr_d;
				cr_q <= cr_d;
				cnt_q <= cnt_d;
			end
			if (cfg_we) begin
				maxc_cfg_q <= cfg_data;
			end
		end
	end

	// The open chunk can never outlast the open write.
	a_chunk_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		hce_pkg::CMP_BITS'(cr_q) <= hce_pkg::CMP_BITS'(wr_q))
		else $error("chunk count exceeds write count");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("job pushed into a full queue");

endmodule
`default_nettype wire

[sv/hce_fifo.sv]
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module hce_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hce_pkg::job_t    wdata,
	input  wire logic             pop,
	output hce_pkg::job_t         head,
	output hce_pkg::q_stat_t      stat
);

	hce_pkg::job_t               mem_q [hce_pkg::QDEPTH];
	logic [hce_pkg::QA-1:0]      wptr_q;
	logic [hce_pkg::QA-1:0]      rptr_q;
	logic [hce_pkg::QA:0]        count_q;

	assign head = mem_q[rptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == (hce_pkg::QA + 1)'(hce_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + hce_pkg::QA'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + hce_pkg::QA'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (hce_pkg::QA + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (hce_pkg::QA + 1)'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (hce_pkg::QA + 1)'(hce_pkg::QDEPTH))
		else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

[sv/hce_back.sv]
// Back end: sequences each queued job into encoded bytes behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module hce_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hce_pkg::job_t    head,
	input  wire hce_pkg::q_stat_t stat,
	output logic                  pop,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output hce_pkg::rsp_t         rsp
);

	hce_pkg::job_t                cur_q;
	logic                         cur_valid_q;
	hce_pkg::step_t               step_q;
	logic [hce_pkg::DIG_BITS-1:0] dig_q;
	logic                         rsp_valid_q;
	hce_pkg::rsp_t                rsp_q;

	hce_pkg::job_t                act_job;
	hce_pkg::step_t               act_step;
	logic [hce_pkg::DIG_BITS-1:0] act_dig;
	hce_pkg::step_t               nxt_step;
	logic [hce_pkg::DIG_BITS-1:0] nxt_dig;
	logic                         done;
	logic                         out_free;
	logic                         emit;
	logic [hce_pkg::HEX_BITS-1:0] hex_shift;
	logic [7:0]                   byte_d;
	logic [31:0]                  total_d;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign emit = (cur_valid_q || !stat.empty) && out_free;
	assign pop = emit && !cur_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		if (cur_valid_q) begin
			act_job = cur_q;
			act_step = step_q;
			act_dig = dig_q;
		end else begin
			act_job = head;
			act_dig = head.top_dig;
			if (head.flush) begin
				act_step = hce_pkg::ST_F0;
			end else if (head.header) begin
				act_step = hce_pkg::ST_HEX;
			end else begin
				act_step = hce_pkg::ST_DATA;
			end
		end
	end

	// Next step of the byte sequencer.
	always_comb begin
		nxt_step = act_step;
		nxt_dig = act_dig;
		done = 1'b0;
		case (act_step)
			hce_pkg::ST_HEX: begin
				if (act_dig == '0) begin
					nxt_step = hce_pkg::ST_HCR;
				end else begin
					nxt_dig = act_dig - hce_pkg::DIG_BITS'(1);
				end
			end
			hce_pkg::ST_HCR: nxt_step = hce_pkg::ST_HLF;
			hce_pkg::ST_HLF: nxt_step = hce_pkg::ST_DATA;
			hce_pkg::ST_DATA: begin
				if (act_job.trailer) begin
					nxt_step = hce_pkg::ST_TCR;
				end else begin
					done = 1'b1;
				end
			end
			hce_pkg::ST_TCR: nxt_step = hce_pkg::ST_TLF;
			hce_pkg::ST_F0: nxt_step = hce_pkg::ST_FCR1;
			hce_pkg::ST_FCR1: nxt_step = hce_pkg::ST_FLF1;
			hce_pkg::ST_FLF1: nxt_step = hce_pkg::ST_FCR2;
			hce_pkg::ST_FCR2: nxt_step = hce_pkg::ST_FLF2;
			default: done = 1'b1;
		endcase
	end

	// Byte and running total for the current step.
	always_comb begin
		hex_shift = hce_pkg::HEX_BITS'(act_job.chunk) >> {act_dig, 2'b00};
		byte_d = hce_pkg::CH_CR;
		total_d = act_job.cnt_post;
		case (act_step)
			hce_pkg::ST_HEX: begin
				byte_d = hce_pkg::hex_char(hex_shift[3:0]);
				total_d = act_job.cnt_pre;
			end
			hce_pkg::ST_HCR: total_d = act_job.cnt_pre;
			hce_pkg::ST_HLF: begin
				byte_d = hce_pkg::CH_LF;
				total_d = act_job.cnt_pre;
			end
			hce_pkg::ST_DATA: byte_d = act_job.data;
			hce_pkg::ST_TCR: byte_d = hce_pkg::CH_CR;
			hce_pkg::ST_TLF: byte_d = hce_pkg::CH_LF;
			hce_pkg::ST_F0: byte_d = hce_pkg::CH_ZERO;
			hce_pkg::ST_FLF1: byte_d = hce_pkg::CH_LF;
			hce_pkg::ST_FLF2: byte_d = hce_pkg::CH_LF;
			default: byte_d = hce_pkg::CH_CR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q <= hce_pkg::ST_DATA;
			dig_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= emit;
			end
			if (emit) begin
				cur_valid_q <= !done;
				step_q <= nxt_step;
				dig_q <= nxt_dig;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			rsp_q.out_byte <= byte_d;
			rsp_q.last <= done;
			rsp_q.payload_total <= total_d;
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("job taken from an empty queue");

endmodule
`default_nettype wire

[sv/http_chunked_encoder.sv]
// Top level of the chunked transfer encoder: front end, job queue and back end.
// An accepted word's job is written into the job queue, then the back end registers
// its first encoded byte at the output. The sequencer emits one encoded byte per cycle
// while rsp_stall allows; a chunk opening adds header bytes, and a flush emits five bytes.
// The four-entry job queue lets words be taken while header bytes are still going out.
// Reset (arst_n low) clears write, chunk and byte counts, empties the queue and sets
// the maximum chunk size to 4096.
`timescale 1ns / 1ps
`default_nettype none
module http_chunked_encoder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire hce_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output hce_pkg::rsp_t        rsp,
	input  wire logic            cfg_we,
	input  wire logic [hce_pkg::CFG_BITS-1:0] cfg_data
);

	hce_pkg::q_stat_t stat;
	hce_pkg::job_t    push_job;
	hce_pkg::job_t    head;
	logic             push;
	logic             pop;

	hce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.push      (push),
		.job       (push_job)
	);

	hce_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	hce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

[test/http_chunked_encoder_test.sv]
// Self-checking testbench for the chunked transfer encoder, with its own predictor and random idling.
`timescale 1ns / 1ps
module http_chunked_encoder_test;
	import hce_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	req_t pending[$];
	rsp_t expected_bytes[$];

	logic [LEN_FIELD_BITS-1:0] write_left = '0;
	logic [CHUNK_BITS-1:0] chunk_left = '0;
	logic [31:0] byte_count = '0;
	logic [CFG_BITS-1:0] chunk_limit = MAX_CHUNK_RESET;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int cycles = 0;

	http_chunked_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void emit(input logic [7:0] b);
		expected_bytes.push_back({b, 1'b0, byte_count});
	endfunction

	function automatic void encode_word(input req_t w);
		int n_prior;
		int d;
		logic [CHUNK_BITS-1:0] limit;
		logic [CHUNK_BITS-1:0] chunk;
		logic [3:0] nib;
		logic started;
		n_prior = expected_bytes.size();
		case (w.func)
		FUNC_BEGIN: begin
			write_left = w.write_length;
			chunk_left = '0;
		end
		FUNC_BYTE: begin
			if (write_left != 0) begin
				if (chunk_left == 0) begin
					limit = (chunk_limit == 0) ? CHUNK_BITS'(1) : chunk_limit;
					chunk = (write_left < limit) ? write_left[CHUNK_BITS-1:0] : limit;
					started = 1'b0;
					for (d = 3; d >= 0; d--) begin
						nib = chunk[4*d +: 4];
						if (nib != 0 || started || d == 0) begin
							started = 1'b1;
							emit((nib > 9) ? {4'h0, nib} + CH_A_OFS : {4'h0, nib} + CH_ZERO);
						end
					end
					emit(CH_CR);
					emit(CH_LF);
					chunk_left = chunk;
				end
				byte_count = byte_count + 32'd1;
				emit(w.data);
				write_left = write_left - LEN_FIELD_BITS'(1);
				chunk_left = chunk_left - CHUNK_BITS'(1);
				if (chunk_left == 0) begin
					emit(CH_CR);
					emit(CH_LF);
				end
			end
		end
		FUNC_FLUSH: begin
			emit(CH_ZERO);
			emit(CH_CR);
			emit(CH_LF);
			emit(CH_CR);
			emit(CH_LF);
			write_left = '0;
			chunk_left = '0;
		end
		default: begin
		end
		endcase
		if (expected_bytes.size() > n_prior) begin
			expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				encode_word(req);
			end
			if (!req_valid || !req_stall) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected word: out_byte %h", rsp.out_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (rsp.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, rsp.out_byte);
						errors++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, rsp.last);
						errors++;
					end
					if (rsp.payload_total !== want.payload_total) begin
						$error("payload_total: expected %0d, got %0d",
							want.payload_total, rsp.payload_total);
						errors++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic void queue_word(input logic [1:0] f, input logic [7:0] d,
			input logic [LEN_FIELD_BITS-1:0] len);
		req_t w;
		w.func = f;
		w.data = d;
		w.write_length = len;
		pending.push_back(w);
	endfunction

	function automatic void queue_random(input int quota);
		int made;
		int len;
		int cut;
		int extra;
		int k;
		made = 0;
		while (made < quota) begin
			case ($urandom_range(9))
			0: begin
				queue_word(2'($urandom_range(3)), 8'($urandom), 24'($urandom));
				made++;
			end
			1: begin
				queue_word(FUNC_FLUSH, 8'($urandom), 24'($urandom));
				made++;
			end
			default: begin
				if ($urandom_range(7) == 0) begin
					len = int'($urandom & 32'h00ff_ffff);
				end else begin
					len = $urandom_range(40);
				end
				cut = (len > 40) ? $urandom_range(12, 1) : len;
				if ($urandom_range(5) == 0) begin
					cut = $urandom_range(cut);
				end
				extra = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
				queue_word(FUNC_BEGIN, 8'($urandom), 24'(len));
				for (k = 0; k < cut + extra; k++) begin
					queue_word(FUNC_BYTE, 8'($urandom), 24'($urandom));
				end
				made += 1 + cut;
			end
			endcase
		end
	endfunction

	task automatic wait_quiet();
		do @(negedge clk);
		while (pending.size() != 0 || req_valid || expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		chunk_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_BITS-1:0] limits[8];
		int p;
		limits = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd16, 16'd4096, 16'd3, 16'd1};
		limits[7] = 16'($urandom_range(40, 1));

		// Stray byte, unused code, a short write, a write replaced mid-chunk, a flush, then a zero-length write.
		queue_word(FUNC_BYTE, 8'hff, 24'hff_ffff);
		queue_word(FUNC_UNUSED, 8'hff, 24'hff_ffff);
		queue_word(FUNC_BEGIN, 8'h00, 24'd3);
		queue_word(FUNC_BYTE, 8'h00, 24'h00_0000);
		queue_word(FUNC_BYTE, 8'hff, 24'hff_ffff);
		queue_word(FUNC_BYTE, 8'h5a, 24'h00_0000);
		queue_word(FUNC_BEGIN, 8'hff, 24'hff_ffff);
		queue_word(FUNC_BYTE, 8'h81, 24'h00_0000);
		queue_word(FUNC_BEGIN, 8'h00, 24'd2);
		queue_word(FUNC_BYTE, 8'h42, 24'h00_0000);
		queue_word(FUNC_FLUSH, 8'hff, 24'hff_ffff);
		queue_word(FUNC_BYTE, 8'h11, 24'h00_0000);
		queue_word(FUNC_BEGIN, 8'h00, 24'd0);
		queue_word(FUNC_BYTE, 8'h22, 24'h00_0000);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait_quiet();
		write_limit(16'd0);
		queue_word(FUNC_BEGIN, 8'h00, 24'd2);
		queue_word(FUNC_BYTE, 8'h01, 24'h00_0000);
		queue_word(FUNC_BYTE, 8'hfe, 24'h00_0000);

		wait_quiet();
		write_limit(16'hffff);
		queue_word(FUNC_BEGIN, 8'h00, 24'hff_ffff);
		queue_word(FUNC_BYTE, 8'hc3, 24'h00_0000);
		queue_word(FUNC_BEGIN, 8'h00, 24'h00_abcd);
		queue_word(FUNC_BYTE, 8'h3c, 24'h00_0000);
		queue_word(FUNC_FLUSH, 8'h00, 24'h00_0000);

		for (p = 0; p < 8; p++) begin
			wait_quiet();
			write_limit(limits[p]);
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 65;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 65;
			end
			default: begin
				send_idle_pct = 7;
				stall_pct = 7;
			end
			endcase
			queue_random(PHASE_WORDS);
		end

		wait_quiet();
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
sv/hce_pkg.sv
sv/hce_front.sv
sv/hce_fifo.sv
sv/hce_back.sv
sv/http_chunked_encoder.sv
test/http_chunked_encoder_test.sv
